>>> rtl/assert_macros.svh
// Assertion helpers shared by the checker files.
// Each macro takes a label, the clock, the active-low reset, a condition and a consequence.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequence must hold in the same cycle as the condition.
`define ASSERT_IMPLY(lbl, clk_i, rst_n_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_n_i) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// The consequence must hold in the cycle after the condition.
`define ASSERT_NEXT(lbl, clk_i, rst_n_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_n_i) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/slbrp_pkg.sv
`timescale 1ns / 1ps

package slbrp_pkg;

	// Widths fixed by the item formats.
	localparam int GS_W     = 5;
	localparam int START_W  = 6;
	localparam int LEN_W    = 7;
	localparam int WORD_W   = 64;
	localparam int POS_W    = 8;
	localparam int OFFSET_W = 26;
	localparam int LENGTH_W = 27;

	// Range end arithmetic needs one bit beyond start plus length.
	localparam int END_W = 8;

	// Defaults and limits.
	localparam int            BITMAP_BITS_DEF = 32;
	localparam logic [GS_W-1:0]  GS_RESET     = 5'd12;
	localparam logic [GS_W-1:0]  GS_MAX       = 5'd20;
	localparam logic [POS_W-1:0] POS_MAX      = 8'hFF;

	// One layer of the snapshot chain.
	typedef struct packed {
		logic                 new_op;
		logic [START_W-1:0]   req_first;
		logic [LEN_W-1:0]     req_len;
		logic [WORD_W-1:0]    layer_bitmap;
		logic [WORD_W-1:0]    layer_inode;
	} layer_item_t;

	// Read plan for one layer.
	typedef struct packed {
		logic                 read_needed;
		logic [POS_W-1:0]     layer_pos;
		logic [WORD_W-1:0]    read_inode;
		logic [OFFSET_W-1:0]  read_offset;
		logic [LENGTH_W-1:0]  read_length;
		logic [WORD_W-1:0]    merged_bitmap;
	} plan_item_t;

endpackage

>>> rtl/slbrp_plan.sv
`timescale 1ns / 1ps

module slbrp_plan #(
	parameter int BITMAP_BITS = slbrp_pkg::BITMAP_BITS_DEF
) (
	input  slbrp_pkg::layer_item_t           layer,
	input  logic [BITMAP_BITS-1:0]           merged_cur,
	input  logic [slbrp_pkg::POS_W-1:0]      pos_cur,
	input  logic [slbrp_pkg::GS_W-1:0]       granule_shift,
	output slbrp_pkg::plan_item_t            plan,
	output logic [BITMAP_BITS-1:0]           merged_nxt,
	output logic [slbrp_pkg::POS_W-1:0]      pos_nxt
);

	import slbrp_pkg::*;

	localparam int IDX_W  = (BITMAP_BITS > 1) ? $clog2(BITMAP_BITS) : 1;
	localparam int SPAN_W = IDX_W + 1;

	logic [BITMAP_BITS-1:0] bitmap;
	logic [BITMAP_BITS-1:0] merged_base;
	logic [POS_W-1:0]       pos_base;
	logic [START_W-1:0]     rng_start;
	logic [END_W-1:0]       rng_end;
	logic [BITMAP_BITS-1:0] rng_mask;
	logic [BITMAP_BITS-1:0] want;
	logic [BITMAP_BITS-1:0] lo_fill;
	logic [BITMAP_BITS-1:0] hi_fill;
	logic [IDX_W-1:0]       first_idx;
	logic [IDX_W-1:0]       last_idx;
	logic [SPAN_W-1:0]      span;
	logic [GS_W-1:0]        shift;
	logic                   needed;

	// A new operation starts from an empty merged bitmap and position zero.
	assign bitmap      = layer.layer_bitmap[BITMAP_BITS-1:0];
	assign merged_base = layer.new_op ? '0 : merged_cur;
	assign pos_base    = layer.new_op ? '0 : pos_cur;

	// Requested range; a zero length covers the whole bitmap.
	always_comb begin
		if (layer.req_len == '0) begin
			rng_start = '0;
			rng_end   = END_W'(BITMAP_BITS);
		end else begin
			rng_start = layer.req_first;
			rng_end   = END_W'(layer.req_first) + END_W'(layer.req_len);
		end
	end

	// Per-bit range test; an end past the bitmap simply covers the top bit.
	always_comb begin
		for (int i = 0; i < BITMAP_BITS; i++) begin
			rng_mask[i] = (END_W'(i) >= END_W'(rng_start)) && (END_W'(i) < rng_end);
		end
	end

	// Granules this layer must supply.
	assign want   = bitmap & ~merged_base & rng_mask;
	assign needed = |want;

	// Smear the wanted bits up and down; their overlap is the trimmed range.
	always_comb begin
		lo_fill = want;
		hi_fill = want;
		for (int k = 1; k < BITMAP_BITS; k = k * 2) begin
			lo_fill = lo_fill | (lo_fill << k);
			hi_fill = hi_fill | (hi_fill >> k);
		end
	end

	// Lowest and highest wanted granule.
	always_comb begin
		first_idx = '0;
		last_idx  = '0;
		for (int i = BITMAP_BITS - 1; i >= 0; i--) begin
			if (want[i]) begin
				first_idx = IDX_W'(i);
			end
		end
		for (int i = 0; i < BITMAP_BITS; i++) begin
			if (want[i]) begin
				last_idx = IDX_W'(i);
			end
		end
	end

	assign span  = SPAN_W'(last_idx) - SPAN_W'(first_idx) + SPAN_W'(1);
	assign shift = (granule_shift > GS_MAX) ? GS_MAX : granule_shift;

	// Merge this layer's bits inside the trimmed range.
	assign merged_nxt = merged_base | (bitmap & lo_fill & hi_fill);

	// The position saturates on long chains.
	assign pos_nxt = (pos_base == POS_MAX) ? pos_base : pos_base + POS_W'(1);

	// Result fields; offset and length are zero when nothing is read.
	always_comb begin
		plan.read_needed   = needed;
		plan.layer_pos     = pos_base;
		plan.read_inode    = layer.layer_inode;
		plan.read_offset   = needed ? (OFFSET_W'(first_idx) << shift) : '0;
		plan.read_length   = needed ? (LENGTH_W'(span) << shift) : '0;
		plan.merged_bitmap = WORD_W'(merged_nxt);
	end

endmodule

>>> rtl/snapshot_layer_bitmap_read_planner.sv
`timescale 1ns / 1ps

// Channel | Direction | Handshake                  | Item
// layer   | in        | layer_valid / layer_stall  | layer_item_t, one chain layer
// plan    | out       | plan_valid / plan_stall    | plan_item_t, one read plan
// cfg     | in        | cfg_wr_en                  | cfg_wr_data, granule shift
//
// Each layer moves from acceptance into the input register and then into the result register,
// which holds its plan. One layer is accepted per cycle unless a plan stall holds it back;
// the merged bitmap and the layer position update when a layer moves into the result
// register, so the next layer sees them at once. Reset clears the merged bitmap, the
// position and both valid flags and sets the granule shift to 12. A stalled plan holds
// its register, and the input register stalls only when it is full and cannot move forward.

module snapshot_layer_bitmap_read_planner #(
	parameter int BITMAP_BITS = slbrp_pkg::BITMAP_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           layer_valid,
	output logic                           layer_stall,
	input  slbrp_pkg::layer_item_t         layer,
	output logic                           plan_valid,
	input  logic                           plan_stall,
	output slbrp_pkg::plan_item_t          plan,
	input  logic                           cfg_wr_en,
	input  logic [slbrp_pkg::GS_W-1:0]     cfg_wr_data
);

	import slbrp_pkg::*;

	logic [GS_W-1:0]        gs_q;
	logic [BITMAP_BITS-1:0] merged_q;
	logic [POS_W-1:0]       pos_q;
	layer_item_t            layer_s1;
	logic                   vld_s1;
	plan_item_t             plan_s2;
	logic                   vld_s2;
	plan_item_t             plan_nxt;
	logic [BITMAP_BITS-1:0] merged_nxt;
	logic [POS_W-1:0]       pos_nxt;
	logic                   out_free;
	logic                   load_s2;
	logic                   s1_free;

	// Handshake control between the two registers.
	assign out_free    = !vld_s2 || !plan_stall;
	assign load_s2     = vld_s1 && out_free;
	assign s1_free     = !vld_s1 || load_s2;
	assign layer_stall = !s1_free;
	assign plan_valid  = vld_s2;
	assign plan        = plan_s2;

	// Planning logic between the input and result registers.
	slbrp_plan #(
		.BITMAP_BITS(BITMAP_BITS)
	) u_plan (
		.layer         (layer_s1),
		.merged_cur    (merged_q),
		.pos_cur       (pos_q),
		.granule_shift (gs_q),
		.plan          (plan_nxt),
		.merged_nxt    (merged_nxt),
		.pos_nxt       (pos_nxt)
	);

	// Control state, configuration and chain state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gs_q     <= GS_RESET;
			merged_q <= '0;
			pos_q    <= '0;
			vld_s1   <= 1'b0;
			vld_s2   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				gs_q <= cfg_wr_data;
			end
			if (s1_free) begin
				vld_s1 <= layer_valid;
			end
			if (out_free) begin
				vld_s2 <= vld_s1;
			end
			if (load_s2) begin
				merged_q <= merged_nxt;
				pos_q    <= pos_nxt;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (s1_free && layer_valid) begin
			layer_s1 <= layer;
		end
		if (load_s2) begin
			plan_s2 <= plan_nxt;
		end
	end

endmodule

>>> rtl/slbrp_chk.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module slbrp_chk #(
	parameter int BITMAP_BITS = slbrp_pkg::BITMAP_BITS_DEF
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  plan_valid,
	input logic                  plan_stall,
	input slbrp_pkg::plan_item_t plan
);

	import slbrp_pkg::*;

	// A plan that is stalled is still offered in the next cycle.
	`ASSERT_NEXT(a_plan_held, clk, arst_n, plan_valid && plan_stall, plan_valid)

	// A layer with nothing to read reports an empty byte range.
	`ASSERT_IMPLY(a_idle_range, clk, arst_n, plan_valid && !plan.read_needed, (plan.read_offset == '0) && (plan.read_length == '0))

	// A layer that must be read covers at least one granule.
	`ASSERT_IMPLY(a_read_len, clk, arst_n, plan_valid && plan.read_needed, plan.read_length != '0)

	// The merged bitmap never holds granules beyond the bitmap size.
	`ASSERT_IMPLY(a_merged_top, clk, arst_n, plan_valid, (plan.merged_bitmap >> BITMAP_BITS) == '0)

endmodule

bind snapshot_layer_bitmap_read_planner slbrp_chk #(
	.BITMAP_BITS(BITMAP_BITS)
) u_slbrp_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.plan_valid (plan_valid),
	.plan_stall (plan_stall),
	.plan       (plan)
);
